// ===== rtl/rcot_pkg.sv =====
// Shared types and codes for the reference-counted object cache table.
// Holds the request and response payload structs and the entry record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcot_pkg;

	localparam logic [2:0] CMD_GET        = 3'd0;
	localparam logic [2:0] CMD_RELEASE    = 3'd1;
	localparam logic [2:0] CMD_MARK_DIRTY = 3'd2;
	localparam logic [2:0] CMD_SYNC_ONE   = 3'd3;
	localparam logic [2:0] CMD_SYNC_ALL   = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_CLAIMED  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_ZERO     = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	localparam logic KIND_FINAL     = 1'b0;
	localparam logic KIND_WRITEBACK = 1'b1;

	localparam logic [15:0] REFS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  device;
		logic [31:0] object_number;
		logic [4:0]  slot;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  entry;
		logic [7:0]  tag_device;
		logic [31:0] tag_number;
		logic [2:0]  status;
		logic [5:0]  written_count;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  device;
		logic [31:0] number;
		logic [15:0] refs;
	} ent_t;

endpackage

`default_nettype wire

// ===== rtl/refcounted_object_cache_table.sv =====
// Top level of the reference-counted object cache table: sequencer, dirty bits, output register.
// Depends on rcot_pkg and rcot_store.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative table of ENTRIES cached objects with reference counts and dirty marks.
// One request is taken at a time; req_ready is high only while the sequencer is idle.
// Get and sync all walk the entry store one entry per cycle through its single read port,
// unless the rsp channel stalls. A writeback result enters the output register in the
// cycle its entry is evaluated and does not hold the walk, except on the matching entry of
// a get, which is evaluated again (a get that hits stops at the matching entry). Release,
// mark dirty and sync one read their slot in S_SLOT_RD and answer in S_SLOT_EV; a dirty
// sync one sends its writeback there before its final. Each result, writeback or final, is
// one rsp transaction and the final one carries last. Unknown commands are dropped with no
// result. The entry output carries the low five bits of the index.
module refcounted_object_cache_table #(
	parameter int ENTRIES = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire rcot_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output rcot_pkg::rsp_t     rsp
);
	import rcot_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SLOT_RD,
		S_SLOT_EV
	} state_t;

	state_t             state_q;
	logic [2:0]         cmd_q;
	logic [7:0]         dev_q;
	logic [31:0]        num_q;
	logic [4:0]         slot_q;
	logic [CW-1:0]      issue_q;
	logic               ev_v_q;
	logic [IW-1:0]      ev_idx_q;
	logic               have_free_q;
	logic [IW-1:0]      free_ix_q;
	logic [CW-1:0]      cnt_q;
	logic [ENTRIES-1:0] dirty_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	ent_t          ent;
	ent_t          wr_data;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] slot_ix;
	logic [IW-1:0] cur_ix;
	logic          cur_dirty;
	logic          oob;
	logic          out_free;
	logic          issue_more;
	logic          scan_end;
	logic          is_free;
	logic          hit;
	logic          wb;
	logic          emit;
	logic          fire;
	rsp_t          emit_val;
	logic          advance;
	logic          finish;
	logic          cnt_inc;
	logic          take_free;
	logic          dirty_clr;
	logic          dirty_set;
	logic [IW-1:0] dirty_ix;

	function automatic rsp_t mk_rsp(logic kind, logic [4:0] entry, logic [7:0] dev,
			logic [31:0] num, logic [2:0] st, logic [5:0] cnt, logic last);
		rsp_t r;
		r.kind          = kind;
		r.entry         = entry;
		r.tag_device    = dev;
		r.tag_number    = num;
		r.status        = st;
		r.written_count = cnt;
		r.last          = last;
		return r;
	endfunction

	rcot_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ent),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign slot_ix    = IW'(slot_q);
	assign oob        = 32'(slot_q) >= ENTRIES;
	assign cur_ix     = (state_q == S_SLOT_EV) ? slot_ix : ev_idx_q;
	assign cur_dirty  = dirty_q[cur_ix];
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign issue_more = issue_q < CW'(ENTRIES);
	assign scan_end   = !ev_v_q && !issue_more;
	assign is_free    = (ent.refs == '0) && !have_free_q;
	assign hit        = (cmd_q == CMD_GET) && (ent.device == dev_q) && (ent.number == num_q);
	assign wb         = (cmd_q == CMD_GET) ? (is_free && cur_dirty) : cur_dirty;
	assign fire       = emit && out_free;

	always_comb begin
		emit      = 1'b0;
		emit_val  = '0;
		advance   = 1'b0;
		finish    = 1'b0;
		cnt_inc   = 1'b0;
		take_free = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = cur_ix;
		wr_data   = ent;
		dirty_clr = 1'b0;
		dirty_set = 1'b0;
		dirty_ix  = cur_ix;
		case (state_q)
			S_SCAN: begin
				if (ev_v_q) begin
					if (wb) begin
						emit     = 1'b1;
						emit_val = mk_rsp(KIND_WRITEBACK, 5'(ev_idx_q), ent.device, ent.number,
							ST_OK, 6'd0, 1'b0);
						if (out_free) begin
							dirty_clr = 1'b1;
							cnt_inc   = 1'b1;
							// hold on this entry so a match is still answered
							advance   = !hit;
						end
					end else if (hit) begin
						emit     = 1'b1;
						emit_val = mk_rsp(KIND_FINAL, 5'(ev_idx_q), dev_q, num_q,
							(ent.refs == REFS_MAX) ? ST_OVERFLOW : ST_OK, 6'(cnt_q), 1'b1);
						if (out_free) begin
							wr_en        = ent.refs != REFS_MAX;
							wr_data.refs = ent.refs + 16'd1;
							finish       = 1'b1;
						end
					end else begin
						advance   = 1'b1;
						take_free = is_free && (cmd_q == CMD_GET);
					end
				end else if (scan_end) begin
					emit = 1'b1;
					if (cmd_q == CMD_SYNC_ALL) begin
						emit_val = mk_rsp(KIND_FINAL, 5'd0, 8'd0, 32'd0, ST_OK, 6'(cnt_q), 1'b1);
					end else if (!have_free_q) begin
						emit_val = mk_rsp(KIND_FINAL, 5'd0, dev_q, num_q, ST_FULL, 6'(cnt_q), 1'b1);
					end else begin
						emit_val = mk_rsp(KIND_FINAL, 5'(free_ix_q), dev_q, num_q, ST_CLAIMED,
							6'(cnt_q), 1'b1);
						if (out_free) begin
							wr_en     = 1'b1;
							wr_addr   = free_ix_q;
							wr_data   = '{device: dev_q, number: num_q, refs: 16'd1};
							dirty_clr = 1'b1;
							dirty_ix  = free_ix_q;
						end
					end
					finish = out_free;
				end else begin
					advance = 1'b1;
				end
			end
			S_SLOT_EV: begin
				emit = 1'b1;
				if (oob) begin
					emit_val = mk_rsp(KIND_FINAL, slot_q, 8'd0, 32'd0, ST_OK, 6'd0, 1'b1);
					finish   = out_free;
				end else if (cmd_q == CMD_SYNC_ONE) begin
					if (cur_dirty) begin
						emit_val = mk_rsp(KIND_WRITEBACK, slot_q, ent.device, ent.number,
							ST_OK, 6'd0, 1'b0);
						dirty_clr = out_free;
						cnt_inc   = out_free;
					end else begin
						emit_val = mk_rsp(KIND_FINAL, slot_q, ent.device, ent.number,
							ST_OK, 6'(cnt_q), 1'b1);
						finish = out_free;
					end
				end else begin
					emit_val = mk_rsp(KIND_FINAL, slot_q, ent.device, ent.number,
						(ent.refs == '0) ? ST_ZERO : ST_OK, 6'd0, 1'b1);
					if (out_free && (ent.refs != '0)) begin
						if (cmd_q == CMD_RELEASE) begin
							wr_en        = 1'b1;
							wr_data.refs = ent.refs - 16'd1;
						end else begin
							dirty_set = 1'b1;
						end
					end
					finish = out_free;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == S_SLOT_RD) begin
			rd_en   = !oob;
			rd_addr = slot_ix;
		end else begin
			rd_en   = advance && issue_more;
			rd_addr = issue_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			dev_q       <= '0;
			num_q       <= '0;
			slot_q      <= '0;
			issue_q     <= '0;
			ev_v_q      <= 1'b0;
			ev_idx_q    <= '0;
			have_free_q <= 1'b0;
			free_ix_q   <= '0;
			cnt_q       <= '0;
			dirty_q     <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				rsp_q       <= emit_val;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (dirty_clr) begin
				dirty_q[dirty_ix] <= 1'b0;
			end
			if (dirty_set) begin
				dirty_q[dirty_ix] <= 1'b1;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (take_free) begin
				have_free_q <= 1'b1;
				free_ix_q   <= ev_idx_q;
			end
			// advance the walk: evaluate the entry read now, read the next one
			if (advance) begin
				ev_v_q   <= issue_more;
				ev_idx_q <= issue_q[IW-1:0];
				if (issue_more) begin
					issue_q <= issue_q + CW'(1);
				end
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q       <= req.cmd;
						dev_q       <= req.device;
						num_q       <= req.object_number;
						slot_q      <= req.slot;
						issue_q     <= '0;
						ev_v_q      <= 1'b0;
						have_free_q <= 1'b0;
						cnt_q       <= '0;
						if ((req.cmd == CMD_GET) || (req.cmd == CMD_SYNC_ALL)) begin
							state_q <= S_SCAN;
						end else if ((req.cmd == CMD_RELEASE) || (req.cmd == CMD_MARK_DIRTY) ||
								(req.cmd == CMD_SYNC_ONE)) begin
							state_q <= S_SLOT_RD;
						end
					end
				end
				S_SLOT_RD: begin
					state_q <= S_SLOT_EV;
				end
				S_SCAN, S_SLOT_EV: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/rcot_store.sv =====
// Entry store of the cache table: tags and reference counts in one memory.
// One write and one registered read per cycle; valid bits make unwritten entries read as zero.
// Depends on rcot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcot_store #(
	parameter int ENTRIES = 32,
	localparam int IW = $clog2(ENTRIES)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            rd_en,
	input  wire logic [IW-1:0]   rd_addr,
	output rcot_pkg::ent_t       rd_data,
	input  wire logic            wr_en,
	input  wire logic [IW-1:0]   wr_addr,
	input  wire rcot_pkg::ent_t  wr_data
);
	import rcot_pkg::*;

	ent_t               mem_q [ENTRIES];
	ent_t               rd_raw_q;
	logic               rd_vld_q;
	logic [ENTRIES-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// never-written entries read as all zero
	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for refcounted_object_cache_table.
// Keeps its own copy of the table, predicts every result and checks it on the rsp channel.
// Depends on rcot_pkg and the RTL of the table.
`timescale 1ns / 1ps

module testbench;

	import rcot_pkg::*;

	localparam int ENTRIES      = 32;
	localparam int STALL_LIMIT  = 4000;
	localparam int IDLE_PERCENT = 7;
	localparam int POOL_SIZE    = 10;

	localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
	localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	bit steady         = 1'b0;
	int mismatch_count = 0;
	int stall_cycles   = 0;

	ent_t cache_ent [ENTRIES] = '{default: '0};
	logic cache_dirty [ENTRIES] = '{default: 1'b0};
	rsp_t expected_rsp [$];

	logic [7:0]  pool_dev [POOL_SIZE];
	logic [31:0] pool_num [POOL_SIZE];

	refcounted_object_cache_table #(
		.ENTRIES(ENTRIES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic rsp_t make_rsp(logic kind, int ent, logic [7:0] dev, logic [31:0] num,
			logic [2:0] st, int count);
		rsp_t r;
		r.kind          = kind;
		r.entry         = ent[4:0];
		r.tag_device    = dev;
		r.tag_number    = num;
		r.status        = st;
		r.written_count = count[5:0];
		r.last          = (kind == KIND_FINAL);
		return r;
	endfunction

	function automatic req_t make_req(logic [2:0] cmd, logic [7:0] dev, logic [31:0] num,
			logic [4:0] slot);
		req_t r;
		r.cmd           = cmd;
		r.device        = dev;
		r.object_number = num;
		r.slot          = slot;
		return r;
	endfunction

	// Clean entry i if dirty and queue its writeback.
	task automatic write_back_entry(input int i, inout int k);
		if (cache_dirty[i]) begin
			expected_rsp.push_back(make_rsp(KIND_WRITEBACK, i, cache_ent[i].device,
				cache_ent[i].number, ST_OK, 0));
			cache_dirty[i] = 1'b0;
			k++;
		end
	endtask

	task automatic predict_cache(input req_t r);
		int k;
		int free_ix;
		bit have_free;
		bit found;
		logic [2:0] st;
		k = 0;
		free_ix = 0;
		have_free = 1'b0;
		found = 1'b0;
		case (r.cmd)
			CMD_GET: begin
				for (int i = 0; i < ENTRIES && !found; i++) begin
					if (cache_ent[i].refs == 0 && !have_free) begin
						if (cache_dirty[i]) begin
							write_back_entry(i, k);
						end else begin
							have_free = 1'b1;
							free_ix = i;
						end
					end
					// a written-back entry still counts as a match
					if (cache_ent[i].device == r.device &&
							cache_ent[i].number == r.object_number) begin
						found = 1'b1;
						st = ST_OK;
						if (cache_ent[i].refs == REFS_MAX)
							st = ST_OVERFLOW;
						else
							cache_ent[i].refs++;
						expected_rsp.push_back(make_rsp(KIND_FINAL, i, r.device,
							r.object_number, st, k));
					end
				end
				if (!found && !have_free) begin
					expected_rsp.push_back(make_rsp(KIND_FINAL, 0, r.device, r.object_number,
						ST_FULL, k));
				end else if (!found) begin
					cache_ent[free_ix].device = r.device;
					cache_ent[free_ix].number = r.object_number;
					cache_ent[free_ix].refs = 16'd1;
					cache_dirty[free_ix] = 1'b0;
					expected_rsp.push_back(make_rsp(KIND_FINAL, free_ix, r.device,
						r.object_number, ST_CLAIMED, k));
				end
			end
			CMD_SYNC_ALL: begin
				for (int i = 0; i < ENTRIES; i++)
					write_back_entry(i, k);
				expected_rsp.push_back(make_rsp(KIND_FINAL, 0, 8'd0, 32'd0, ST_OK, k));
			end
			CMD_RELEASE, CMD_MARK_DIRTY: begin
				st = ST_OK;
				if (cache_ent[r.slot].refs == 0)
					st = ST_ZERO;
				else if (r.cmd == CMD_RELEASE)
					cache_ent[r.slot].refs--;
				else
					cache_dirty[r.slot] = 1'b1;
				expected_rsp.push_back(make_rsp(KIND_FINAL, r.slot, cache_ent[r.slot].device,
					cache_ent[r.slot].number, st, 0));
			end
			CMD_SYNC_ONE: begin
				write_back_entry(r.slot, k);
				expected_rsp.push_back(make_rsp(KIND_FINAL, r.slot, cache_ent[r.slot].device,
					cache_ent[r.slot].number, ST_OK, k));
			end
			default: begin
				// reserved commands produce nothing
			end
		endcase
	endtask

	// Hold valid until accepted; valid only drops when an idle gap is taken.
	task automatic send_item(input req_t item);
		if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < IDLE_PERCENT);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_cache(item);
	endtask

	function automatic int find_tag(logic [7:0] dev, logic [31:0] num);
		for (int i = 0; i < ENTRIES; i++)
			if (cache_ent[i].device == dev && cache_ent[i].number == num)
				return i;
		return -1;
	endfunction

	// Return a referenced entry, searching from a random start; -1 if none.
	function automatic int pick_held();
		int start;
		int j;
		start = $urandom_range(ENTRIES - 1);
		for (int n = 0; n < ENTRIES; n++) begin
			j = (start + n) % ENTRIES;
			if (cache_ent[j].refs != 0)
				return j;
		end
		return -1;
	endfunction

	function automatic int count_referenced();
		int c;
		c = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (cache_ent[i].refs != 0)
				c++;
		return c;
	endfunction

	task automatic test_unfilled_entries();
		// untouched entries carry tag zero and hit a get for device 0, object 0
		send_item(make_req(CMD_GET, 8'h00, 32'h0000_0000, 5'd31));
		send_item(make_req(CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0));
		send_item(make_req(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd0));
		send_item(make_req(CMD_MARK_DIRTY, 8'hFF, 32'hFFFF_FFFF, 5'd0));
		send_item(make_req(CMD_MARK_DIRTY, 8'h00, 32'h0000_0000, 5'd31));
	endtask

	task automatic test_claim_and_release();
		int e;
		send_item(make_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0));
		send_item(make_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31));
		e = find_tag(8'hFF, 32'hFFFF_FFFF);
		send_item(make_req(CMD_MARK_DIRTY, 8'h00, 32'h0, 5'(e)));
		send_item(make_req(CMD_RELEASE, 8'h00, 32'h0, 5'(e)));
		send_item(make_req(CMD_RELEASE, 8'h00, 32'h0, 5'(e)));
		send_item(make_req(CMD_RELEASE, 8'h00, 32'h0, 5'(e)));
	endtask

	task automatic test_writeback_paths();
		int e;
		// the dirty free entry left behind is written back by this scan
		send_item(make_req(CMD_GET, 8'h42, 32'h1234_5678, 5'd7));
		e = find_tag(8'h42, 32'h1234_5678);
		send_item(make_req(CMD_SYNC_ONE, 8'h00, 32'h0, 5'(e)));
		send_item(make_req(CMD_MARK_DIRTY, 8'h00, 32'h0, 5'(e)));
		send_item(make_req(CMD_SYNC_ONE, 8'h00, 32'h0, 5'(e)));
		send_item(make_req(CMD_MARK_DIRTY, 8'h00, 32'h0, 5'(e)));
		send_item(make_req(CMD_RELEASE, 8'h00, 32'h0, 5'(e)));
		// dirty and unreferenced, but a free entry precedes it: hit with no writeback
		send_item(make_req(CMD_GET, 8'h42, 32'h1234_5678, 5'd7));
		send_item(make_req(CMD_GET, 8'h17, 32'h8000_0001, 5'd0));
		send_item(make_req(CMD_MARK_DIRTY, 8'h00, 32'h0, 5'(e)));
		send_item(make_req(CMD_MARK_DIRTY, 8'h00, 32'h0,
			5'(find_tag(8'h17, 32'h8000_0001))));
		send_item(make_req(CMD_SYNC_ALL, 8'hFF, 32'hFFFF_FFFF, 5'd31));
		send_item(make_req(CMD_SYNC_ALL, 8'h00, 32'h0, 5'd0));
	endtask

	task automatic test_reserved_commands();
		for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
			send_item(make_req(3'(c), 8'($urandom), $urandom, 5'($urandom)));
		send_item(make_req(CMD_SYNC_ALL, 8'h00, 32'h0, 5'd0));
	endtask

	task automatic test_table_full();
		int held;
		while (count_referenced() < ENTRIES)
			send_item(make_req(CMD_GET, 8'($urandom), $urandom, 5'($urandom)));
		send_item(make_req(CMD_GET, 8'($urandom), $urandom, 5'($urandom)));
		// a hit still succeeds on a full table
		held = pick_held();
		send_item(make_req(CMD_GET, cache_ent[held].device, cache_ent[held].number,
			5'($urandom)));
		// leave every entry dirty and free: the next get writes back all of them
		for (int i = 0; i < ENTRIES; i++) begin
			send_item(make_req(CMD_MARK_DIRTY, 8'($urandom), $urandom, 5'(i)));
			while (cache_ent[i].refs != 0)
				send_item(make_req(CMD_RELEASE, 8'($urandom), $urandom, 5'(i)));
		end
		send_item(make_req(CMD_GET, 8'($urandom), $urandom, 5'($urandom)));
		send_item(make_req(CMD_GET, 8'($urandom), $urandom, 5'($urandom)));
	endtask

	task automatic test_random_traffic(input int count);
		int sel;
		int j;
		int held;
		req_t r;
		pool_dev[0] = 8'h00;
		pool_num[0] = 32'h0000_0000;
		pool_dev[1] = 8'hFF;
		pool_num[1] = 32'hFFFF_FFFF;
		for (int p = 2; p < POOL_SIZE; p++) begin
			pool_dev[p] = 8'($urandom);
			pool_num[p] = $urandom;
		end
		for (int n = 0; n < count; n++) begin
			steady = (n >= count / 3 && n < count / 2);
			sel = $urandom_range(99);
			held = pick_held();
			r = make_req(CMD_GET, 8'($urandom), $urandom, 5'($urandom));
			if (sel < 38) begin
				j = $urandom_range(POOL_SIZE - 1);
				r.device = pool_dev[j];
				r.object_number = pool_num[j];
			end else if (sel < 43) begin
				r.cmd = CMD_GET;
			end else if (sel < 66) begin
				r.cmd = CMD_RELEASE;
				if (held >= 0)
					r.slot = 5'(held);
			end else if (sel < 70) begin
				r.cmd = CMD_RELEASE;
			end else if (sel < 81) begin
				r.cmd = CMD_MARK_DIRTY;
				if (held >= 0)
					r.slot = 5'(held);
			end else if (sel < 84) begin
				r.cmd = CMD_MARK_DIRTY;
			end else if (sel < 92) begin
				r.cmd = CMD_SYNC_ONE;
			end else if (sel < 96) begin
				r.cmd = CMD_SYNC_ALL;
			end else begin
				r.cmd = 3'($urandom_range(CMD_RESERVED_LAST, CMD_RESERVED_FIRST));
			end
			send_item(r);
		end
		steady = 1'b0;
	endtask

	task automatic test_repeated_hits();
		// stack references on entry 0 back to back, then drop them all again
		steady = 1'b1;
		repeat (6)
			send_item(make_req(CMD_GET, cache_ent[0].device, cache_ent[0].number,
				5'($urandom)));
		steady = 1'b0;
		while (cache_ent[0].refs != 0)
			send_item(make_req(CMD_RELEASE, 8'h00, 32'h0, 5'd0));
		send_item(make_req(CMD_RELEASE, 8'h00, 32'h0, 5'd0));
		send_item(make_req(CMD_GET, cache_ent[0].device, cache_ent[0].number, 5'd0));
		send_item(make_req(CMD_SYNC_ALL, 8'h00, 32'h0, 5'd0));
	endtask

	always @(posedge clk)
		rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected transaction: expected none, actual %0h", $time, rsp);
				mismatch_count++;
			end else begin
				want = expected_rsp.pop_front();
				check_field("kind", want.kind, rsp.kind);
				check_field("entry", want.entry, rsp.entry);
				check_field("tag_device", want.tag_device, rsp.tag_device);
				check_field("tag_number", want.tag_number, rsp.tag_number);
				check_field("status", want.status, rsp.status);
				check_field("written_count", want.written_count, rsp.written_count);
				check_field("last", want.last, rsp.last);
			end
		end
	end

	// Count cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unfilled_entries();
		test_claim_and_release();
		test_writeback_paths();
		test_reserved_commands();
		test_table_full();
		test_random_traffic(280);
		test_repeated_hits();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (4 * ENTRIES) @(posedge clk);
		if (mismatch_count == 0 && expected_rsp.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
